>>> hdl/lats_pkg.sv
// lats_pkg: shared constants, payload types and register codes for the
// toroidal life automaton step engine
// no dependencies
package lats_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 32;
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_IDX_W = $clog2(MAX_COLS);
  localparam int COL_CNT_W = 6;
  localparam int ROWS_REG_W = 5;
  localparam int CFG_DATA_W = 6;
  localparam int NBR_CNT_W = 4;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // command actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // life rule counts
  localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [NBR_CNT_W-1:0] SURVIVE_LOW = 4'd2;
  localparam logic [NBR_CNT_W-1:0] SURVIVE_HIGH = 4'd3;

  // register reset values and size bounds
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 5'd10;
  localparam logic [COL_CNT_W-1:0] COLS_RESET = 6'd20;
  localparam int MIN_SIZE = 3;

  typedef struct packed {
    logic action;
    logic [3:0] row_index;
    logic [31:0] row_cells;
  } cmd_t;

  typedef struct packed {
    logic [3:0] out_row;
    logic [31:0] out_cells;
    logic last_row;
  } result_t;

endpackage

>>> hdl/lats_cell.sv
// lats_cell: one row register of the grid ring, with direct load, clear
// and shift from its neighbor
// depends on lats_pkg
module lats_cell (
  input  logic clk,
  input  logic rst,
  input  logic load_en,
  input  logic [lats_pkg::MAX_COLS-1:0] load_data,
  input  logic clear_en,
  input  logic shift_en,
  input  logic [lats_pkg::MAX_COLS-1:0] shift_data,
  output logic [lats_pkg::MAX_COLS-1:0] row_q
);

  // row storage, grid starts all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
    end else if (load_en) begin
      row_q <= load_data;
    end else if (clear_en) begin
      row_q <= '0;
    end else if (shift_en) begin
      row_q <= shift_data;
    end
  end

endmodule

>>> hdl/lats_rule.sv
// lats_rule: next generation of one row from the rows above and below,
// columns wrapped by the active column count
// depends on lats_pkg
module lats_rule (
  input  logic [lats_pkg::MAX_COLS-1:0] up,
  input  logic [lats_pkg::MAX_COLS-1:0] cur,
  input  logic [lats_pkg::MAX_COLS-1:0] dn,
  input  logic [lats_pkg::COL_CNT_W-1:0] cols,
  output logic [lats_pkg::MAX_COLS-1:0] nxt
);

  logic [lats_pkg::COL_IDX_W-1:0] last_col;

  assign last_col = lats_pkg::COL_IDX_W'(cols - lats_pkg::COL_CNT_W'(1));

  // per column neighbor count and rule, all columns independent
  always_comb begin
    logic [lats_pkg::COL_IDX_W-1:0] lf;
    logic [lats_pkg::COL_IDX_W-1:0] rt;
    logic [lats_pkg::NBR_CNT_W-1:0] sum;
    nxt = '0;
    for (int c = 0; c < lats_pkg::MAX_COLS; c++) begin
      lf = (c == 0) ? last_col : lats_pkg::COL_IDX_W'(c - 1);
      rt = (lats_pkg::COL_CNT_W'(c + 1) == cols) ? '0 : lats_pkg::COL_IDX_W'(c + 1);
      sum = lats_pkg::NBR_CNT_W'(up[lf]) + lats_pkg::NBR_CNT_W'(up[c])
          + lats_pkg::NBR_CNT_W'(up[rt]) + lats_pkg::NBR_CNT_W'(cur[lf])
          + lats_pkg::NBR_CNT_W'(cur[rt]) + lats_pkg::NBR_CNT_W'(dn[lf])
          + lats_pkg::NBR_CNT_W'(dn[c]) + lats_pkg::NBR_CNT_W'(dn[rt]);
      if (lats_pkg::COL_CNT_W'(c) < cols) begin
        if (cur[c]) begin
          nxt[c] = (sum >= lats_pkg::SURVIVE_LOW) && (sum <= lats_pkg::SURVIVE_HIGH);
        end else begin
          nxt[c] = (sum == lats_pkg::BIRTH_COUNT);
        end
      end
    end
  end

endmodule

>>> hdl/life_automaton_torus_step.sv
// life_automaton_torus_step: B3/S23 life on a torus, grid held in a ring of row cells
// load: row written into its cell, no result. advance: first row out after the running
// and result registers, then one row per cycle; busy while stepping, new start taken once idle
// throughput set by the single row rule unit stepping once around the cell ring
// rst (synchronous) clears the grid, sets 10 rows and 20 columns
// results are strobed for one cycle; the receiver cannot stall
module life_automaton_torus_step (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  lats_pkg::cmd_t cmd,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [lats_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic result_valid,
  output lats_pkg::result_t result
);

  localparam int RW = lats_pkg::MAX_COLS;

  logic [lats_pkg::ROWS_REG_W-1:0] active_rows;
  logic [lats_pkg::COL_CNT_W-1:0] active_cols;
  logic [lats_pkg::ROW_CNT_W-1:0] eff_rows;
  logic [lats_pkg::COL_CNT_W-1:0] eff_cols;
  logic [lats_pkg::ROW_IDX_W-1:0] last_idx;
  logic [RW-1:0] col_mask;

  logic running;
  logic [lats_pkg::ROW_IDX_W-1:0] step;
  logic [RW-1:0] prev_row;
  logic [RW-1:0] first_row;
  logic [RW-1:0] row_q [lats_pkg::MAX_ROWS];
  logic [RW-1:0] new_row;
  logic [RW-1:0] dn_row;
  logic accept;
  logic do_load;
  logic do_advance;
  logic last_step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= lats_pkg::ROWS_RESET;
      active_cols <= lats_pkg::COLS_RESET;
    end else if (cfg_write) begin
      if (cfg_index == lats_pkg::CFG_ROWS) begin
        active_rows <= cfg_data[lats_pkg::ROWS_REG_W-1:0];
      end else begin
        active_cols <= cfg_data;
      end
    end
  end

  // clamp sizes to the supported range
  always_comb begin
    if (active_rows < lats_pkg::ROWS_REG_W'(lats_pkg::MIN_SIZE)) begin
      eff_rows = lats_pkg::ROW_CNT_W'(lats_pkg::MIN_SIZE);
    end else if (active_rows > lats_pkg::ROWS_REG_W'(lats_pkg::MAX_ROWS)) begin
      eff_rows = lats_pkg::ROW_CNT_W'(lats_pkg::MAX_ROWS);
    end else begin
      eff_rows = lats_pkg::ROW_CNT_W'(active_rows);
    end
    if (active_cols < lats_pkg::COL_CNT_W'(lats_pkg::MIN_SIZE)) begin
      eff_cols = lats_pkg::COL_CNT_W'(lats_pkg::MIN_SIZE);
    end else if (active_cols > lats_pkg::COL_CNT_W'(lats_pkg::MAX_COLS)) begin
      eff_cols = lats_pkg::COL_CNT_W'(lats_pkg::MAX_COLS);
    end else begin
      eff_cols = active_cols;
    end
  end

  assign last_idx = lats_pkg::ROW_IDX_W'(eff_rows - lats_pkg::ROW_CNT_W'(1));
  assign col_mask = RW'((33'd1 << eff_cols) - 33'd1);

  // transaction decode
  assign busy = running;
  assign accept = start && !running;
  assign do_load = accept && (cmd.action == lats_pkg::ACT_LOAD)
                   && (lats_pkg::ROW_CNT_W'(cmd.row_index) < eff_rows);
  assign do_advance = accept && (cmd.action == lats_pkg::ACT_ADVANCE);
  assign last_step = running && (step == last_idx);

  // row ring: cell 0 is the head, the new row enters at the last active cell
  for (genvar i = 0; i < lats_pkg::MAX_ROWS; i++) begin : g_cell
    logic [RW-1:0] shift_in;
    if (i == lats_pkg::MAX_ROWS - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_mid
      assign shift_in = (lats_pkg::ROW_IDX_W'(i) == last_idx) ? new_row : row_q[i+1];
    end
    lats_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_en    (do_load && (cmd.row_index == lats_pkg::ROW_IDX_W'(i))),
      .load_data  (cmd.row_cells & col_mask),
      .clear_en   (do_advance && (lats_pkg::ROW_CNT_W'(i) >= eff_rows)),
      .shift_en   (running && (lats_pkg::ROW_CNT_W'(i) < eff_rows)),
      .shift_data (shift_in),
      .row_q      (row_q[i])
    );
  end

  // below the head is the next old row, except on the wrap where the saved first row serves
  assign dn_row = last_step ? first_row : row_q[1];

  lats_rule u_rule (
    .up   (prev_row),
    .cur  (row_q[0]),
    .dn   (dn_row),
    .cols (eff_cols),
    .nxt  (new_row)
  );

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step <= '0;
    end else if (do_advance) begin
      running <= 1'b1;
      step <= '0;
    end else if (running) begin
      running <= !last_step;
      step <= step + lats_pkg::ROW_IDX_W'(1);
    end
  end

  // saved old rows for the wrapped neighbors
  always_ff @(posedge clk) begin
    if (do_advance) begin
      prev_row <= row_q[last_idx];
      first_row <= row_q[0];
    end else if (running) begin
      prev_row <= row_q[0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= running;
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      result.out_row <= step;
      result.out_cells <= new_row;
      result.last_row <= last_step;
    end
  end

  // a generation starts only from an advance transaction
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && cmd.action == lats_pkg::ACT_ADVANCE))
    else $error("busy rose without an advance transaction");

  // rows come out in ascending order without gaps
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_row |=>
      result_valid && (result.out_row == $past(result.out_row) + 4'd1))
    else $error("result rows not consecutive");

  // the marked row ends the burst
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_row |=> !result_valid)
    else $error("result after last row");

  // emitted rows stay inside the active area
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (lats_pkg::ROW_CNT_W'(result.out_row) < eff_rows)
                     && ((result.out_cells & ~col_mask) == '0))
    else $error("result outside active area");

endmodule
